/* sv/byte_ring_fifo_with_peek_defines.svh */
// Assertion macros for the byte ring FIFO.
// Each expects clk and rst to be visible where it is used.
`ifndef BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH

// Same-cycle implication check
`define BRF_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define BRF_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/brf_pkg.sv */
package brf_pkg;

  // Field widths
  localparam int CNT_W  = 9;
  localparam int DATA_W = 8;
  localparam int REQ_W  = 2;
  localparam int OFS_W  = 8;
  localparam int RUN_W  = 7;

  // Default sizing
  localparam int BRF_DEPTH   = 256;
  localparam int BRF_MAX_RUN = 64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DROP = 2'd3;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              status;
    logic              last;
    logic [CNT_W-1:0]  level;
    logic [CNT_W-1:0]  free_space;
  } res_t;

  // p + n modulo depth, valid while p + n < 2 * depth
  function automatic logic [CNT_W-1:0] wrap_add(input logic [CNT_W-1:0] p,
                                                input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] depth);
    logic [CNT_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= {1'b0, depth}) begin
      s = s - {1'b0, depth};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

/* sv/brf_ram.sv */
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/brf_seq.sv */
module brf_seq #(
  parameter int DEPTH   = 256,
  parameter int MAX_RUN = 64
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [brf_pkg::CNT_W-1:0]                  cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [brf_pkg::REQ_W-1:0]                  req_type,
  input  logic [brf_pkg::DATA_W-1:0]                 data_in,
  input  logic [brf_pkg::OFS_W-1:0]                  start_offset,
  input  logic [brf_pkg::RUN_W-1:0]                  run_count,
  input  logic                                       out_take,
  output logic                                       res_valid,
  output brf_pkg::res_t                              res,
  output logic                                       mem_we,
  output logic [$clog2((DEPTH < 511) ? DEPTH : 511)-1:0] mem_waddr,
  output logic [brf_pkg::DATA_W-1:0]                 mem_wdata,
  output logic                                       mem_re,
  output logic [$clog2((DEPTH < 511) ? DEPTH : 511)-1:0] mem_raddr,
  input  logic [brf_pkg::DATA_W-1:0]                 mem_rdata
);
  import brf_pkg::*;

  // Usable depth is bounded by the 9-bit depth register
  localparam int EFF_DEPTH = (DEPTH < 511) ? DEPTH : 511;
  localparam int ADDR_W    = $clog2(EFF_DEPTH);
  localparam int RC_W      = $clog2(MAX_RUN + 1);
  localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(EFF_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_RST = CNT_W'((EFF_DEPTH < 256) ? EFF_DEPTH : 256);
  localparam logic [RUN_W-1:0] RUN_MAX   = RUN_W'(MAX_RUN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state;
  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] wp;
  logic [CNT_W-1:0] rp;
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] ptr;
  logic [RC_W-1:0]  remain;
  logic             is_pop;
  logic             pend;
  logic             pend_last;
  logic [CNT_W-1:0] pend_free;

  logic             accept;
  logic             adv;
  logic             issue;
  logic [CNT_W-1:0] level;
  logic [OFS_W-1:0] start_eff;
  logic [CNT_W-1:0] need;
  logic             refuse_run;
  logic             is_push;
  logic             full;
  logic             start_run;
  logic             s_status;
  logic [CNT_W-1:0] s_free;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] cfg_depth;

  // Request decode and admission checks
  assign level     = depth - free_cnt;
  assign in_stall  = (state != ST_IDLE) || pend || !out_take;
  assign accept    = in_valid && !in_stall;
  assign is_push   = (req_type == REQ_PUSH);
  assign full      = (free_cnt == '0);
  assign start_eff = (req_type == REQ_PEEK) ? start_offset : '0;
  assign need      = CNT_W'(start_eff) + CNT_W'(run_count);
  assign refuse_run = (run_count > RUN_MAX) || (need > level);
  assign start_run = accept && !is_push && !refuse_run && (run_count != '0) &&
                     (req_type != REQ_DROP);

  // Single-result outcome: push, refusal, drop or empty run
  always_comb begin
    s_status = 1'b0;
    s_free   = free_cnt;
    if (is_push) begin
      if (full) begin
        s_status = 1'b1;
      end else begin
        s_free = free_cnt - CNT_W'(1);
      end
    end else if (refuse_run) begin
      s_status = 1'b1;
    end else if (req_type != REQ_PEEK) begin
      s_free = free_cnt + CNT_W'(run_count);
    end
  end

  // Run read issue; one read in flight, held while the output is full
  assign adv     = !pend || out_take;
  assign issue   = (state == ST_RUN) && adv;
  assign ptr_inc = wrap_add(ptr, CNT_W'(1), depth);

  assign mem_we    = accept && is_push && !full;
  assign mem_waddr = wp[ADDR_W-1:0];
  assign mem_wdata = data_in;
  assign mem_re    = issue;
  assign mem_raddr = ptr[ADDR_W-1:0];

  // Result mux: read data in flight or a single result
  assign res_valid = (pend && out_take) || (accept && !start_run);
  always_comb begin
    if (pend) begin
      res.data       = mem_rdata;
      res.status     = 1'b0;
      res.last       = pend_last;
      res.level      = depth - pend_free;
      res.free_space = pend_free;
    end else begin
      res.data       = '0;
      res.status     = s_status;
      res.last       = 1'b1;
      res.level      = depth - s_free;
      res.free_space = s_free;
    end
  end

  // Clamp a written depth into 1..EFF_DEPTH
  always_comb begin
    cfg_depth = cfg_data;
    if (cfg_data == '0) begin
      cfg_depth = CNT_W'(1);
    end else if (cfg_data > DEPTH_MAX) begin
      cfg_depth = DEPTH_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      depth    <= DEPTH_RST;
      free_cnt <= DEPTH_RST;
      wp       <= '0;
      rp       <= '0;
      pend     <= 1'b0;
    end else begin
      // Accept a request
      if (accept) begin
        if (start_run) begin
          state  <= ST_RUN;
          ptr    <= wrap_add(rp, CNT_W'(start_eff), depth);
          remain <= run_count[RC_W-1:0];
          is_pop <= (req_type == REQ_POP);
        end else begin
          free_cnt <= s_free;
          if (mem_we) begin
            wp <= wrap_add(wp, CNT_W'(1), depth);
          end
          if (!is_push && !refuse_run && (req_type != REQ_PEEK)) begin
            rp <= wrap_add(rp, CNT_W'(run_count), depth);
          end
        end
      end

      // Run: one byte per issued read
      if (issue) begin
        ptr       <= ptr_inc;
        remain    <= remain - RC_W'(1);
        pend      <= 1'b1;
        pend_last <= (remain == RC_W'(1));
        if (is_pop) begin
          rp        <= ptr_inc;
          free_cnt  <= free_cnt + CNT_W'(1);
          pend_free <= free_cnt + CNT_W'(1);
        end else begin
          pend_free <= free_cnt;
        end
        if (remain == RC_W'(1)) begin
          state <= ST_IDLE;
        end
      end else if (out_take) begin
        pend <= 1'b0;
      end

      // Depth write flushes the buffer
      if (cfg_we) begin
        depth    <= cfg_depth;
        free_cnt <= cfg_depth;
        wp       <= '0;
        rp       <= '0;
      end
    end
  end

endmodule

/* sv/byte_ring_fifo_with_peek.sv */
// Byte ring FIFO with run pop, peek and drop.
// Config: depth_in_use_we writes depth_in_use (clamped to 1..min(DEPTH, 511)) and
// flushes the buffer; write only while the block is idle.
// Input channel: in_valid/in_stall carry one request (req_type, data_in,
// start_offset, run_count); accepted when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall carry result items through an output
// register; each item reports status, level and free_space.
// Push, drop, refusals and empty runs give one item, visible the cycle after
// acceptance; the next request can be taken in that same cycle, so these
// requests sustain one per cycle while the output drains.
// Pop and peek runs read the byte store once per cycle through its one read
// port; each byte passes the store's registered read and then the output
// register, one byte per cycle while the output is not stalled; the block
// takes no new request until the last read has moved to the output register.
// A stalled output holds its item and pauses the run without loss.
// Reset (rst, synchronous) empties the buffer and sets depth to min(256, DEPTH);
// no clearing pass is needed, as only held bytes are ever read.
module byte_ring_fifo_with_peek #(
  parameter int DEPTH   = brf_pkg::BRF_DEPTH,
  parameter int MAX_RUN = brf_pkg::BRF_MAX_RUN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        depth_in_use_we,
  input  logic [brf_pkg::CNT_W-1:0]   depth_in_use,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brf_pkg::REQ_W-1:0]   req_type,
  input  logic [brf_pkg::DATA_W-1:0]  data_in,
  input  logic [brf_pkg::OFS_W-1:0]   start_offset,
  input  logic [brf_pkg::RUN_W-1:0]   run_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brf_pkg::DATA_W-1:0]  data_out,
  output logic                        status,
  output logic                        last,
  output logic [brf_pkg::CNT_W-1:0]   level,
  output logic [brf_pkg::CNT_W-1:0]   free_space
);
  import brf_pkg::*;

`include "byte_ring_fifo_with_peek_defines.svh"

  localparam int EFF_DEPTH = (DEPTH < 511) ? DEPTH : 511;
  localparam int ADDR_W    = $clog2(EFF_DEPTH);

  logic              out_take;
  logic              res_valid;
  res_t              res;
  res_t              ores;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  brf_seq #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (depth_in_use_we),
    .cfg_data     (depth_in_use),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .data_in      (data_in),
    .start_offset (start_offset),
    .run_count    (run_count),
    .out_take     (out_take),
    .res_valid    (res_valid),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  brf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (EFF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: free, or being emptied this cycle
  assign out_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      ores <= res;
    end
  end

  assign data_out   = ores.data;
  assign status     = ores.status;
  assign last       = ores.last;
  assign level      = ores.level;
  assign free_space = ores.free_space;

  // Checks
  `BRF_CHECK(a_no_overwrite, res_valid, out_take, "result offered while output held")
  `BRF_CHECK(a_refuse_shape, out_valid && status, (data_out == '0) && last,
             "refused item carries data or is not last")
  `BRF_CHECK(a_level_bound, out_valid,
             ({1'b0, level} + {1'b0, free_space}) <= (CNT_W + 1)'(EFF_DEPTH),
             "level plus free space exceeds depth")
  `BRF_CHECK_NEXT(a_run_holds_input, res_valid && !res.last, in_stall,
                  "input taken in the middle of a run")

endmodule

/* tb/byte_ring_fifo_with_peek_test.sv */
module byte_ring_fifo_with_peek_test;
  import brf_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving on either side
  localparam int HOLD_LEN      = 300;   // long output hold-off
  localparam int SETTLE_CYCLES = 4;     // run pipeline settles before a depth write
  localparam int DRAIN_CYCLES  = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               depth_in_use_we = 1'b0;
  logic [CNT_W-1:0]   depth_in_use = CNT_W'(BRF_DEPTH);
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   req_type = REQ_PUSH;
  logic [DATA_W-1:0]  data_in = '0;
  logic [OFS_W-1:0]   start_offset = '0;
  logic [RUN_W-1:0]   run_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  data_out;
  logic               status;
  logic               last;
  logic [CNT_W-1:0]   level;
  logic [CNT_W-1:0]   free_space;

  // Shadow copy of the ring and its pointers
  logic [DATA_W-1:0]  ring_mem [BRF_DEPTH];
  int                 ring_depth;
  int                 wr_ptr;
  int                 rd_ptr;
  int                 free_cnt;
  res_t               expected_results [$];
  res_t               oldest_result;

  int                 send_idle_pct;
  int                 stall_pct;
  int                 fail_count = 0;
  int                 idle_cycles;
  int                 hold_req_cnt;
  int                 hold_seen_cnt;
  int                 hold_left;

  byte_ring_fifo_with_peek u_dut (
    .clk            (clk),
    .rst            (rst),
    .depth_in_use_we(depth_in_use_we),
    .depth_in_use   (depth_in_use),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .data_in        (data_in),
    .start_offset   (start_offset),
    .run_count      (run_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_out       (data_out),
    .status         (status),
    .last           (last),
    .level          (level),
    .free_space     (free_space)
  );

  always #HALF_PERIOD clk = ~clk;

  // Queue one expected item; level and free space come from the shadow state
  function automatic void expect_result(input logic [DATA_W-1:0] d, input logic st,
                                        input logic lst);
    res_t r;
    r.data       = d;
    r.status     = st;
    r.last       = lst;
    r.level      = CNT_W'(ring_depth - free_cnt);
    r.free_space = CNT_W'(free_cnt);
    expected_results.push_back(r);
  endfunction

  // Apply one request to the shadow ring and queue the items it yields
  function automatic void ring_predict(input logic [REQ_W-1:0] req,
                                       input logic [DATA_W-1:0] d,
                                       input logic [OFS_W-1:0] ofs,
                                       input logic [RUN_W-1:0] cnt);
    int held;
    int skip;
    int p;
    int i;
    logic [DATA_W-1:0] b;
    held = ring_depth - free_cnt;
    if (req == REQ_PUSH) begin
      if (free_cnt == 0) begin
        expect_result('0, 1'b1, 1'b1);
      end else begin
        ring_mem[wr_ptr] = d;
        wr_ptr = (wr_ptr + 1) % ring_depth;
        free_cnt--;
        expect_result('0, 1'b0, 1'b1);
      end
    end else begin
      skip = (req == REQ_PEEK) ? int'(ofs) : 0;
      if (int'(cnt) > BRF_MAX_RUN || skip + int'(cnt) > held) begin
        expect_result('0, 1'b1, 1'b1);
      end else if (req == REQ_DROP || cnt == 0) begin
        if (req != REQ_PEEK) begin
          rd_ptr = (rd_ptr + int'(cnt)) % ring_depth;
          free_cnt += int'(cnt);
        end
        expect_result('0, 1'b0, 1'b1);
      end else begin
        // pop and peek emit one byte per item; pop frees as it goes
        p = (rd_ptr + skip) % ring_depth;
        for (i = 0; i < int'(cnt); i++) begin
          b = ring_mem[p];
          p = (p + 1) % ring_depth;
          if (req == REQ_POP) begin
            rd_ptr = p;
            free_cnt++;
          end
          expect_result(b, 1'b0, i == int'(cnt) - 1);
        end
      end
    end
  endfunction

  // Offer one request, with random gaps ahead of it, and wait until it is taken
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] d,
                              input logic [OFS_W-1:0] ofs, input logic [RUN_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    data_in      <= d;
    start_offset <= ofs;
    run_count    <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ring_predict(req, d, ofs, cnt);
  endtask

  // Sender goes quiet until every expected item has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Depth write flushes the ring; only done with the block idle
  task automatic write_depth(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    depth_in_use_we <= 1'b1;
    depth_in_use    <= value;
    @(posedge clk);
    depth_in_use_we <= 1'b0;
    ring_depth = (value == 0) ? 1 : ((int'(value) > BRF_DEPTH) ? BRF_DEPTH : int'(value));
    wr_ptr     = 0;
    rd_ptr     = 0;
    free_cnt   = ring_depth;
  endtask

  // Mostly well-formed requests sized to the current level, some out of range
  task automatic random_request();
    int held;
    int cnt;
    int ofs;
    int roll;
    logic [REQ_W-1:0] req;
    held = ring_depth - free_cnt;
    if ($urandom_range(99) < ((2 * held < ring_depth) ? 60 : 35)) begin
      req = REQ_PUSH;
    end else begin
      case ($urandom_range(2))
        0:       req = REQ_POP;
        1:       req = REQ_PEEK;
        default: req = REQ_DROP;
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 75) begin
      cnt = $urandom_range((held < BRF_MAX_RUN) ? held : BRF_MAX_RUN, 0);
    end else if (roll < 90) begin
      cnt = $urandom_range(127);
    end else begin
      cnt = (held < 127) ? held + 1 : 127;
    end
    if ($urandom_range(99) < 80 && cnt <= held) begin
      ofs = $urandom_range(held - cnt, 0);
      if (ofs > 255) ofs = 255;
    end else begin
      ofs = $urandom_range(255);
    end
    send_request(req, DATA_W'($urandom_range(255)), OFS_W'(ofs), RUN_W'(cnt));
  endtask

  // Empty-ring cases, refusals, short runs at full depth
  task automatic test_basic_requests();
    send_request(REQ_DROP, 8'h00, 8'd0, 7'd0);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd1);
    send_request(REQ_PEEK, 8'h00, 8'd0, 7'd0);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd65);
    send_request(REQ_PUSH, 8'h00, 8'd0, 7'd0);
    send_request(REQ_PUSH, 8'hFF, 8'hFF, 7'h7F);
    send_request(REQ_PUSH, 8'h5A, 8'd0, 7'd0);
    send_request(REQ_PEEK, 8'h00, 8'd1, 7'd2);
    send_request(REQ_PEEK, 8'h00, 8'd2, 7'd2);
    send_request(REQ_PEEK, 8'h00, 8'd255, 7'd0);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd127);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd1);
    send_request(REQ_DROP, 8'h00, 8'd0, 7'd1);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd1);
  endtask

  // Depth zero acts as one; a depth of three forces pointer wrap
  task automatic test_small_depths();
    write_depth(9'd0);
    send_request(REQ_PUSH, 8'hAA, 8'd0, 7'd0);
    send_request(REQ_PUSH, 8'h55, 8'd0, 7'd0);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd1);
    write_depth(9'd3);
    send_request(REQ_PUSH, 8'h01, 8'd0, 7'd0);
    send_request(REQ_PUSH, 8'h02, 8'd0, 7'd0);
    send_request(REQ_PUSH, 8'h03, 8'd0, 7'd0);
    send_request(REQ_PUSH, 8'h04, 8'd0, 7'd0);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd2);
    send_request(REQ_PUSH, 8'h05, 8'd0, 7'd0);
    send_request(REQ_PUSH, 8'h06, 8'd0, 7'd0);
    send_request(REQ_PEEK, 8'h00, 8'd0, 7'd3);
    send_request(REQ_DROP, 8'h00, 8'd0, 7'd3);
  endtask

  // Oversized depth clamps to the full store; longest runs on a full 64-byte ring
  task automatic test_full_max_depth();
    write_depth(9'h1FF);
    send_request(REQ_PUSH, 8'h3C, 8'd0, 7'd0);
    write_depth(9'd64);
    repeat (BRF_MAX_RUN) send_request(REQ_PUSH, DATA_W'($urandom_range(255)), '0, '0);
    send_request(REQ_PEEK, 8'h00, 8'd0, 7'd65);
    send_request(REQ_PEEK, 8'h00, 8'd1, 7'd64);
    send_request(REQ_PEEK, 8'h00, 8'd0, 7'd64);
    send_request(REQ_POP, 8'h00, 8'd0, 7'd32);
    send_request(REQ_DROP, 8'h00, 8'd0, 7'd32);
  endtask

  // Output held off for a long stretch while pushes keep coming
  task automatic test_output_hold_off();
    write_depth(9'd8);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req_cnt++;
    repeat (12) send_request(REQ_PUSH, DATA_W'($urandom_range(255)), '0, '0);
    wait_drained();
    send_request(REQ_POP, 8'h00, 8'd0, 7'd8);
  endtask

  // Random traffic at one depth and one idling mix, with a full pause midway
  task automatic test_random_traffic(input int n, input logic [CNT_W-1:0] depth,
                                     input int idle_pct, input int stall_in_pct);
    write_depth(depth);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    repeat (n / 2) random_request();
    wait_drained();
    repeat (n - n / 2) random_request();
  endtask

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall     <= 1'b0;
      hold_left     <= 0;
      hold_seen_cnt <= 0;
    end else if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left     <= HOLD_LEN;
      out_stall     <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want_v,
                                      input logic [CNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Compare each item taken from the block with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, got data=%0d status=%0d last=%0d",
                 $time, data_out, status, last);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("data_out", CNT_W'(oldest_result.data), CNT_W'(data_out));
        check_field("status", CNT_W'(oldest_result.status), CNT_W'(status));
        check_field("last", CNT_W'(oldest_result.last), CNT_W'(last));
        check_field("level", oldest_result.level, level);
        check_field("free_space", oldest_result.free_space, free_space);
      end
    end
  end

  // Watchdog: too long with nothing moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || depth_in_use_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req_cnt  = 0;
    ring_depth    = BRF_DEPTH;
    wr_ptr        = 0;
    rd_ptr        = 0;
    free_cnt      = BRF_DEPTH;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_requests();
    test_small_depths();
    test_full_max_depth();
    test_output_hold_off();
    test_random_traffic(6, 9'd256, 0, 0);
    test_random_traffic(6, 9'd5, 60, 0);
    test_random_traffic(6, 9'd2, 0, 60);
    test_random_traffic(6, 9'd64, 12, 12);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
